>>> rtl/core/shfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_pkg: shared types and codes of the sync-header frame receiver
// Field widths, input action codes, event codes and register indexes.
// ----------------------------------------------------------------------------
package shfr_pkg;

  localparam int unsigned ActW     = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned EventW   = 3;
  localparam int unsigned LenW     = 7;
  localparam int unsigned PosW     = 6;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [ActW-1:0] {
    ACT_BYTE    = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_READ    = 2'd2,
    ACT_DISCARD = 2'd3
  } action_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_SUM_BAD  = 3'd2,
    EV_DROP     = 3'd3,
    EV_LEN_REJ  = 3'd4,
    EV_TIMEOUT  = 3'd5
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_HDR  = 2'd0,
    CFG_SECOND_HDR = 2'd1,
    CFG_TIMEOUT    = 2'd2
  } cfg_idx_e;

endpackage

>>> rtl/core/shfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_if: channel interfaces of the sync-header frame receiver
// Input word channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface shfr_in_if import shfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface shfr_out_if import shfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_code;
  logic              mailbox_full_flag;
  logic              read_valid;
  logic [ByteW-1:0]  msg_cmd;
  logic [LenW-1:0]   msg_len;
  logic [ByteW-1:0]  payload_byte;
  logic [PosW-1:0]   payload_position;
  logic              last;

  modport source (output valid, event_code, mailbox_full_flag, read_valid, msg_cmd,
                  msg_len, payload_byte, payload_position, last, input ready);
  modport sink   (input valid, event_code, mailbox_full_flag, read_valid, msg_cmd,
                  msg_len, payload_byte, payload_position, last, output ready);
endinterface

interface shfr_cfg_if import shfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/sync_header_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_frame_receiver: frame parser with a one-frame mailbox
// Parses H1 H2 LEN CMD PAYLOAD SUM frames from line bytes, keeps one good
// frame in a mailbox and streams it out on request.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  - one word per action: line byte, tick, mailbox read, discard.
//   out_chan - result words; each input word gives one result, except a
//              read of a full mailbox, which gives one word per payload byte
//              (one word if the frame has no payload); last marks the end.
//   cfg_chan - register writes (header bytes, idle timeout), always ready;
//              write only while the block is idle.
// Result timing:
//   The result of a byte, tick, discard or empty read is registered at the
//   accepting edge. A mailbox read steps through an address state and a
//   data state for each payload byte, as the payload memory has one write
//   port and one read port with registered read data.
// Payload bytes live in one memory of two banks: one bank captures the frame
// being parsed, the other holds the mailbox; a stored frame swaps the banks.
// Reset empties the mailbox and puts the parser on the hunt for the first
// header byte; the payload memory needs no clearing. While the result
// register is held by a stalled receiver, no new input word is taken and a
// read stream pauses.
// ----------------------------------------------------------------------------
module sync_header_frame_receiver import shfr_pkg::*; #(
  parameter int unsigned PAYLOAD_LIMIT = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  shfr_in_if.sink    in_chan,
  shfr_out_if.source out_chan,
  shfr_cfg_if.sink   cfg_chan
);

  localparam int unsigned Depth = 2 * PAYLOAD_LIMIT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdxW  = (PAYLOAD_LIMIT > 1) ? $clog2(PAYLOAD_LIMIT) : 1;
  localparam logic [ByteW-1:0] LimitByte = ByteW'(PAYLOAD_LIMIT);
  localparam logic [LenW-1:0]  LimitLen  = LenW'(PAYLOAD_LIMIT);
  localparam logic [AddrW-1:0] BankBase  = AddrW'(PAYLOAD_LIMIT);

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_CMD   = 3'd3,
    PH_PAY   = 3'd4,
    PH_SUM   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA
  } state_e;

  typedef struct packed {
    logic [EventW-1:0] event_code;
    logic              mailbox_full_flag;
    logic              read_valid;
    logic [ByteW-1:0]  msg_cmd;
    logic [LenW-1:0]   msg_len;
    logic [ByteW-1:0]  payload_byte;
    logic [PosW-1:0]   payload_position;
    logic              last;
  } out_t;

  // registers
  state_e               state_q;
  logic                 out_valid_q;
  out_t                 out_q;
  logic [ByteW-1:0]     first_hdr_q, second_hdr_q;
  logic [TimeoutW-1:0]  timeout_q;
  phase_e               phase_q, phase_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [ByteW-1:0]     cmd_q, cmd_d;
  logic [LenW-1:0]      fill_q, fill_d;
  logic [ByteW-1:0]     sum_q, sum_d;
  logic [TimeoutW-1:0]  idle_q, idle_d;
  logic                 occ_q, occ_d;
  logic                 mbx_bank_q, mbx_bank_d;
  logic [ByteW-1:0]     mbx_cmd_q, mbx_cmd_d;
  logic [LenW-1:0]      mbx_len_q, mbx_len_d;
  logic [LenW-1:0]      rd_pos_q;
  logic [ByteW-1:0]     mem_q [Depth];
  logic [ByteW-1:0]     rdata_q;

  // step logic
  event_e               ev_d;
  logic                 clear_parser;
  phase_e               clear_phase;
  logic [TimeoutW-1:0]  idle_inc;
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic                 mem_re;
  logic                 in_fire, out_take, out_free;
  logic                 out_load;
  logic                 read_full;
  logic [LenW-1:0]      rd_pos_next;
  logic [ByteW-1:0]     b;

  assign b         = in_chan.data_byte;
  assign out_free  = !out_valid_q || out_chan.ready;
  assign out_take  = out_valid_q && out_chan.ready;
  assign in_chan.ready = (state_q == S_IDLE) && out_free;
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign read_full = (in_chan.action == ACT_READ) && occ_q;
  assign cfg_chan.ready = 1'b1;

  // a new result word enters the output register
  assign out_load  = (state_q == S_IDLE) ? (in_fire && !(read_full && (mbx_len_q != '0)))
                                         : ((state_q == S_RD_DATA) && out_free);

  // capture bank is always the one the mailbox does not hold
  assign mem_waddr = mbx_bank_q ? AddrW'(fill_q[IdxW-1:0])
                                : BankBase + AddrW'(fill_q[IdxW-1:0]);
  assign mem_raddr = mbx_bank_q ? BankBase + AddrW'(rd_pos_q[IdxW-1:0])
                                : AddrW'(rd_pos_q[IdxW-1:0]);
  assign mem_re    = (state_q == S_RD_ADDR);
  assign rd_pos_next = rd_pos_q + LenW'(1);
  assign idle_inc  = (idle_q == '1) ? idle_q : idle_q + TimeoutW'(1);

  always_comb begin
    phase_d      = phase_q;
    len_d        = len_q;
    cmd_d        = cmd_q;
    fill_d       = fill_q;
    sum_d        = sum_q;
    idle_d       = idle_q;
    occ_d        = occ_q;
    mbx_bank_d   = mbx_bank_q;
    mbx_cmd_d    = mbx_cmd_q;
    mbx_len_d    = mbx_len_q;
    ev_d         = EV_NONE;
    mem_we       = 1'b0;
    clear_parser = 1'b0;
    clear_phase  = PH_HUNT1;
    case (in_chan.action)
      ACT_BYTE: begin
        idle_d = '0;
        unique case (phase_q)
          PH_HUNT1: begin
            if (b == first_hdr_q) phase_d = PH_HUNT2;
          end
          PH_HUNT2: begin
            if (b == second_hdr_q) begin
              phase_d = PH_LEN;
            end else begin
              clear_parser = 1'b1;
              clear_phase  = (b == first_hdr_q) ? PH_HUNT2 : PH_HUNT1;
            end
          end
          PH_LEN: begin
            if (b > LimitByte) begin
              ev_d         = EV_LEN_REJ;
              clear_parser = 1'b1;
              clear_phase  = (b == first_hdr_q) ? PH_HUNT2 : PH_HUNT1;
            end else begin
              len_d   = b[LenW-1:0];
              fill_d  = '0;
              sum_d   = b;
              phase_d = PH_CMD;
            end
          end
          PH_CMD: begin
            cmd_d   = b;
            sum_d   = sum_q + b;
            phase_d = (len_q == '0) ? PH_SUM : PH_PAY;
          end
          PH_PAY: begin
            mem_we = (fill_q < LimitLen);
            sum_d  = sum_q + b;
            fill_d = fill_q + LenW'(1);
            if (fill_d >= len_q) phase_d = PH_SUM;
          end
          PH_SUM: begin
            if (b != sum_q) begin
              ev_d = EV_SUM_BAD;
            end else if (occ_q) begin
              ev_d = EV_DROP;
            end else begin
              // swap banks instead of copying the payload
              mbx_cmd_d  = cmd_q;
              mbx_len_d  = len_q;
              mbx_bank_d = ~mbx_bank_q;
              occ_d      = 1'b1;
              ev_d       = EV_STORED;
            end
            clear_parser = 1'b1;
          end
          default: clear_parser = 1'b1;
        endcase
      end
      ACT_TICK: begin
        if (phase_q != PH_HUNT1) begin
          idle_d = idle_inc;
          if (idle_inc >= timeout_q) begin
            clear_parser = 1'b1;
            ev_d         = EV_TIMEOUT;
          end
        end
      end
      ACT_DISCARD: begin
        occ_d        = 1'b0;
        clear_parser = 1'b1;
      end
      default: ;
    endcase
    if (clear_parser) begin
      phase_d = clear_phase;
      len_d   = '0;
      cmd_d   = '0;
      fill_d  = '0;
      sum_d   = '0;
      idle_d  = '0;
    end
  end

  // control state, parser state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      first_hdr_q  <= 8'hAA;
      second_hdr_q <= 8'h55;
      timeout_q    <= 16'd50;
      phase_q      <= PH_HUNT1;
      len_q        <= '0;
      cmd_q        <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      idle_q       <= '0;
      occ_q        <= 1'b0;
      mbx_bank_q   <= 1'b0;
      mbx_cmd_q    <= '0;
      mbx_len_q    <= '0;
      rd_pos_q     <= '0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        unique case (cfg_chan.index)
          CFG_FIRST_HDR:  first_hdr_q  <= cfg_chan.data[ByteW-1:0];
          CFG_SECOND_HDR: second_hdr_q <= cfg_chan.data[ByteW-1:0];
          CFG_TIMEOUT:    timeout_q    <= cfg_chan.data[TimeoutW-1:0];
          default: ;
        endcase
      end
      if (out_load)      out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (read_full) begin
              occ_q    <= 1'b0;
              rd_pos_q <= '0;
              if (mbx_len_q != '0) state_q <= S_RD_ADDR;
            end else begin
              phase_q     <= phase_d;
              len_q       <= len_d;
              cmd_q       <= cmd_d;
              fill_q      <= fill_d;
              sum_q       <= sum_d;
              idle_q      <= idle_d;
              occ_q       <= occ_d;
              mbx_bank_q  <= mbx_bank_d;
              mbx_cmd_q   <= mbx_cmd_d;
              mbx_len_q   <= mbx_len_d;
            end
          end
        end
        S_RD_ADDR: state_q <= S_RD_DATA;
        S_RD_DATA: begin
          if (out_free) begin
            rd_pos_q    <= rd_pos_next;
            state_q     <= (rd_pos_next == mbx_len_q) ? S_IDLE : S_RD_ADDR;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result payload; loaded whenever out_valid_q is set above
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_q.event_code        <= read_full ? EV_NONE : ev_d;
          out_q.mailbox_full_flag <= read_full ? 1'b0 : occ_d;
          out_q.read_valid        <= read_full;
          out_q.msg_cmd           <= read_full ? mbx_cmd_q : '0;
          out_q.msg_len           <= read_full ? mbx_len_q : '0;
          out_q.payload_byte      <= '0;
          out_q.payload_position  <= '0;
          out_q.last              <= 1'b1;
        end
      end
      S_RD_DATA: begin
        if (out_free) begin
          out_q.event_code        <= EV_NONE;
          out_q.mailbox_full_flag <= 1'b0;
          out_q.read_valid        <= 1'b1;
          out_q.msg_cmd           <= mbx_cmd_q;
          out_q.msg_len           <= mbx_len_q;
          out_q.payload_byte      <= rdata_q;
          out_q.payload_position  <= rd_pos_q[PosW-1:0];
          out_q.last              <= (rd_pos_next == mbx_len_q);
        end
      end
      default: ;
    endcase
  end

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire && mem_we) mem_q[mem_waddr] <= b;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign out_chan.valid             = out_valid_q;
  assign out_chan.event_code        = out_q.event_code;
  assign out_chan.mailbox_full_flag = out_q.mailbox_full_flag;
  assign out_chan.read_valid        = out_q.read_valid;
  assign out_chan.msg_cmd           = out_q.msg_cmd;
  assign out_chan.msg_len           = out_q.msg_len;
  assign out_chan.payload_byte      = out_q.payload_byte;
  assign out_chan.payload_position  = out_q.payload_position;
  assign out_chan.last              = out_q.last;

  // a bank swap only ever fills an empty mailbox
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mbx_bank_q != $past(mbx_bank_q)) |-> (occ_q && !$past(occ_q)))
    else $error("mailbox bank swapped while mailbox was occupied");

  // no capture write may land while the mailbox is being streamed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (!in_chan.ready && !(in_fire && mem_we)))
    else $error("input taken during mailbox readout");

  // a streamed payload word never reports a full mailbox
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.read_valid) |-> (!out_q.mailbox_full_flag && !occ_q))
    else $error("mailbox still occupied during readout");

  // readout position stays inside the stored frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_DATA) |-> (rd_pos_q < mbx_len_q))
    else $error("readout position beyond frame length");

endmodule

>>> verif/tb_sync_header_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_header_frame_receiver: self-checking bench of the frame receiver
// Drives line bytes, ticks, mailbox reads and discards through the input
// channel. Each accepted word runs through a behavioural model of the parser
// and mailbox, and every result word is compared field by field with the
// oldest word the model says the block owes. A short directed table comes
// first. Random framed traffic follows under several header and timeout
// settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_sync_header_frame_receiver;
  import shfr_pkg::*;

  localparam int unsigned FRAME_MAX = 32;

  typedef enum logic [2:0] {
    SEEK_FIRST  = 3'd0,
    SEEK_SECOND = 3'd1,
    GET_LEN     = 3'd2,
    GET_CMD     = 3'd3,
    GET_PAY     = 3'd4,
    GET_SUM     = 3'd5
  } rx_phase_e;

  typedef struct packed {
    event_e      ev;
    logic        full;
    logic        rd;
    logic [7:0]  cmd;
    logic [6:0]  len;
    logic [7:0]  pb;
    logic [5:0]  pos;
    logic        last;
  } rx_word_t;

  typedef struct packed {
    action_e    act;
    logic [7:0] b;
    logic       typed;
    event_e     ev;
    logic       full;
  } plan_row_t;

  typedef struct packed {
    logic [7:0]  h1;
    logic [7:0]  h2;
    logic [15:0] tmo;
    logic [6:0]  gap;
    logic [6:0]  stall;
    logic        hold;
    logic [9:0]  items;
  } run_setting_t;

  logic clk_i;
  logic rst_ni;

  shfr_in_if  in_if ();
  shfr_out_if out_if ();
  shfr_cfg_if cfg_if ();

  sync_header_frame_receiver #(
    .PAYLOAD_LIMIT(FRAME_MAX)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // register copies
  logic [7:0]  hdr1;
  logic [7:0]  hdr2;
  logic [15:0] idle_limit;

  // parser and mailbox copies
  rx_phase_e   rx_phase;
  logic [6:0]  rx_len;
  logic [7:0]  rx_cmd;
  logic [6:0]  rx_fill;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_capture [FRAME_MAX];
  logic [15:0] rx_idle;
  logic        mbox_full;
  logic [7:0]  mbox_cmd;
  logic [6:0]  mbox_len;
  logic [7:0]  mbox_bytes [FRAME_MAX];

  rx_word_t    owed_words [$];
  rx_word_t    due_w;
  int unsigned fail_count;
  int unsigned words_offered;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  bit          hold_start;
  bit          cur_typed;
  event_e      cur_ev;
  logic        cur_full;

  plan_row_t plan [25] = '{
    '{ACT_TICK,    8'h00, 1'b1, EV_NONE,    1'b0},
    '{ACT_READ,    8'hFF, 1'b1, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'hAA, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h55, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'hFF, 1'b1, EV_LEN_REJ, 1'b0},
    '{ACT_BYTE,    8'hAA, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'hAA, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h55, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h00, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'hFF, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'hFF, 1'b1, EV_STORED,  1'b1},
    '{ACT_BYTE,    8'hAA, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h55, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h21, 1'b1, EV_LEN_REJ, 1'b1},
    '{ACT_BYTE,    8'hAA, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h55, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h01, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h00, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h80, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'h81, 1'b1, EV_DROP,    1'b1},
    '{ACT_TICK,    8'h00, 1'b1, EV_NONE,    1'b1},
    '{ACT_READ,    8'h00, 1'b0, EV_NONE,    1'b0},
    '{ACT_BYTE,    8'hAA, 1'b0, EV_NONE,    1'b0},
    '{ACT_TICK,    8'h00, 1'b0, EV_NONE,    1'b0},
    '{ACT_DISCARD, 8'h00, 1'b1, EV_NONE,    1'b0}
  };

  run_setting_t runs [5] = '{
    '{8'h00, 8'hFF, 16'd1,     7'd0,  7'd0,  1'b0, 10'd80},
    '{8'hFF, 8'h00, 16'hFFFF,  7'd84, 7'd0,  1'b0, 10'd60},
    '{8'h5A, 8'h5A, 16'd3,     7'd0,  7'd84, 1'b1, 10'd60},
    '{8'hAA, 8'h55, 16'd50,    7'd25, 7'd25, 1'b0, 10'd80},
    '{8'h12, 8'h34, 16'd2,     7'd0,  7'd0,  1'b0, 10'd60}
  };

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void clear_parser(input rx_phase_e ph);
    rx_phase = ph;
    rx_len   = '0;
    rx_cmd   = '0;
    rx_fill  = '0;
    rx_sum   = '0;
    rx_idle  = '0;
  endfunction

  function automatic event_e take_byte(input logic [7:0] b);
    event_e ev;
    ev = EV_NONE;
    case (rx_phase)
      SEEK_FIRST: begin
        if (b == hdr1) rx_phase = SEEK_SECOND;
      end
      SEEK_SECOND: begin
        if (b == hdr2) rx_phase = GET_LEN;
        else clear_parser((b == hdr1) ? SEEK_SECOND : SEEK_FIRST);
      end
      GET_LEN: begin
        if (b > FRAME_MAX) begin
          ev = EV_LEN_REJ;
          clear_parser((b == hdr1) ? SEEK_SECOND : SEEK_FIRST);
        end else begin
          rx_len   = b[6:0];
          rx_fill  = '0;
          rx_sum   = b;
          rx_phase = GET_CMD;
        end
      end
      GET_CMD: begin
        rx_cmd   = b;
        rx_sum   = rx_sum + b;
        rx_phase = (rx_len == 0) ? GET_SUM : GET_PAY;
      end
      GET_PAY: begin
        rx_capture[rx_fill[4:0]] = b;
        rx_sum  = rx_sum + b;
        rx_fill = rx_fill + 7'd1;
        if (rx_fill >= rx_len) rx_phase = GET_SUM;
      end
      GET_SUM: begin
        if (b != rx_sum) begin
          ev = EV_SUM_BAD;
        end else if (mbox_full) begin
          ev = EV_DROP;
        end else begin
          mbox_cmd  = rx_cmd;
          mbox_len  = rx_len;
          for (int unsigned i = 0; i < rx_len; i++) mbox_bytes[i] = rx_capture[i];
          mbox_full = 1'b1;
          ev = EV_STORED;
        end
        clear_parser(SEEK_FIRST);
      end
      default: clear_parser(SEEK_FIRST);
    endcase
    rx_idle = '0;
    return ev;
  endfunction

  // work out the result words one accepted input word owes
  function automatic void step_receiver(input action_e act, input logic [7:0] b);
    event_e      ev;
    int unsigned n;
    rx_word_t    w;
    ev = EV_NONE;
    if (act == ACT_READ && mbox_full) begin
      n = (mbox_len == 0) ? 1 : 32'(mbox_len);
      mbox_full = 1'b0;
      for (int unsigned k = 0; k < n; k++) begin
        w.ev   = EV_NONE;
        w.full = 1'b0;
        w.rd   = 1'b1;
        w.cmd  = mbox_cmd;
        w.len  = mbox_len;
        w.pb   = (k < mbox_len) ? mbox_bytes[k] : 8'h00;
        w.pos  = k[5:0];
        w.last = (k + 1 == n);
        owed_words.push_back(w);
      end
    end else begin
      case (act)
        ACT_BYTE: ev = take_byte(b);
        ACT_TICK: begin
          if (rx_phase != SEEK_FIRST) begin
            if (rx_idle != 16'hFFFF) rx_idle = rx_idle + 16'd1;
            if (rx_idle >= idle_limit) begin
              clear_parser(SEEK_FIRST);
              ev = EV_TIMEOUT;
            end
          end
        end
        ACT_DISCARD: begin
          mbox_full = 1'b0;
          clear_parser(SEEK_FIRST);
        end
        default: ;
      endcase
      w.ev   = ev;
      w.full = mbox_full;
      w.rd   = 1'b0;
      w.cmd  = '0;
      w.len  = '0;
      w.pb   = '0;
      w.pos  = '0;
      w.last = 1'b1;
      owed_words.push_back(w);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] due_v,
                                      input logic [7:0] got_v);
    if (due_v !== got_v) begin
      fail_count++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, due_v, got_v);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      step_receiver(action_e'(in_if.action), in_if.data_byte);
      // a typed row states the word outright
      if (cur_typed) begin
        owed_words[owed_words.size() - 1] = '{cur_ev, cur_full, 1'b0, 8'h00, 7'h00,
                                              8'h00, 6'h00, 1'b1};
      end
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (owed_words.size() == 0) begin
        fail_count++;
        $display("%0t ns: result word expected none, got event %0d read %0b byte 0x%0h",
                 $time, out_if.event_code, out_if.read_valid, out_if.payload_byte);
      end else begin
        due_w = owed_words.pop_front();
        check_field("event_code", 8'(due_w.ev), 8'(out_if.event_code));
        check_field("mailbox_full_flag", 8'(due_w.full), 8'(out_if.mailbox_full_flag));
        check_field("read_valid", 8'(due_w.rd), 8'(out_if.read_valid));
        check_field("msg_cmd", due_w.cmd, out_if.msg_cmd);
        check_field("msg_len", 8'(due_w.len), 8'(out_if.msg_len));
        check_field("payload_byte", due_w.pb, out_if.payload_byte);
        check_field("payload_position", 8'(due_w.pos), 8'(out_if.payload_position));
        check_field("last", 8'(due_w.last), 8'(out_if.last));
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic offer_word(input action_e act, input logic [7:0] b, input bit typed,
                            input event_e ev, input logic full);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cur_typed = typed;
    cur_ev    = ev;
    cur_full  = full;
    in_if.action    <= act;
    in_if.data_byte <= b;
    in_if.valid     <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_offered++;
    @(negedge clk_i);
  endtask

  task automatic send_line(input action_e act, input logic [7:0] b);
    offer_word(act, b, 1'b0, EV_NONE, 1'b0);
  endtask

  // hold the input until every owed word is out, then let the block settle
  task automatic drain(input int unsigned settle);
    int unsigned waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (owed_words.size() != 0 && waited < 50000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [15:0] tmo);
    cfg_idx_e    idx;
    logic [15:0] val;
    for (int i = 0; i < 3; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_FIRST_HDR:  val = {8'h00, h1};
        CFG_SECOND_HDR: val = {8'h00, h2};
        default:        val = tmo;
      endcase
      cfg_if.index <= idx;
      cfg_if.data  <= val;
      cfg_if.valid <= 1'b1;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      case (idx)
        CFG_FIRST_HDR:  hdr1 = val[7:0];
        CFG_SECOND_HDR: hdr2 = val[7:0];
        default:        idle_limit = val;
      endcase
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // mostly framed traffic with random content, some frames broken, the rest reads, discards, ticks and random words
  task automatic random_traffic(input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    int unsigned flen;
    int unsigned nb;
    int unsigned nt;
    logic [7:0]  fr [37];
    logic [7:0]  sum;
    bit          cut;
    target = words_offered + n_items;
    while (words_offered < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 19))
          0:       flen = FRAME_MAX;
          1:       flen = $urandom_range(FRAME_MAX + 1, 255);
          2, 3, 4: flen = $urandom_range(9, FRAME_MAX - 1);
          default: flen = $urandom_range(0, 8);
        endcase
        fr[0] = hdr1;
        fr[1] = hdr2;
        fr[2] = flen[7:0];
        nb = 3;
        if (flen <= FRAME_MAX) begin
          fr[3] = 8'($urandom_range(0, 255));
          sum = fr[2] + fr[3];
          for (int unsigned k = 0; k < flen; k++) begin
            fr[4 + k] = 8'($urandom_range(0, 255));
            sum = sum + fr[4 + k];
          end
          if ($urandom_range(0, 99) < 15) sum = sum ^ 8'($urandom_range(1, 255));
          fr[4 + flen] = sum;
          nb = flen + 5;
        end
        cut = ($urandom_range(0, 9) == 0);
        if (cut) nb = $urandom_range(1, nb - 1);
        for (int unsigned k = 0; k < nb; k++) begin
          if ($urandom_range(0, 99) < 5) send_line(ACT_TICK, 8'($urandom_range(0, 255)));
          send_line(ACT_BYTE, fr[k]);
        end
        // let a broken frame age out where the timeout is short
        if (cut && idle_limit <= 60) begin
          for (int unsigned k = 0; k <= idle_limit; k++) send_line(ACT_TICK, 8'h00);
        end
      end else if (pick < 70) begin
        send_line(ACT_READ, 8'($urandom_range(0, 255)));
      end else if (pick < 74) begin
        send_line(ACT_DISCARD, 8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        nt = ($urandom_range(0, 3) == 0 && idle_limit <= 60) ? idle_limit + 1
                                                              : $urandom_range(1, 3);
        for (int unsigned k = 0; k < nt; k++) send_line(ACT_TICK, 8'($urandom_range(0, 255)));
      end else begin
        send_line(action_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_BYTE;
    in_if.data_byte = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_FIRST_HDR;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    hold_start    = 1'b0;
    hold_left     = 0;
    send_gap_pct  = 0;
    stall_pct     = 0;
    fail_count    = 0;
    words_offered = 0;
    cur_typed     = 1'b0;
    cur_ev        = EV_NONE;
    cur_full      = 1'b0;
    hdr1       = 8'hAA;
    hdr2       = 8'h55;
    idle_limit = 16'd50;
    clear_parser(SEEK_FIRST);
    mbox_full = 1'b0;
    mbox_cmd  = '0;
    mbox_len  = '0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) offer_word(plan[i].act, plan[i].b, plan[i].typed, plan[i].ev,
                                 plan[i].full);

    foreach (runs[p]) begin
      drain(8);
      program_regs(runs[p].h1, runs[p].h2, runs[p].tmo);
      send_gap_pct = runs[p].gap;
      stall_pct    = runs[p].stall;
      if (runs[p].hold) hold_start = 1'b1;
      random_traffic(runs[p].items);
    end

    drain(60);
    if (owed_words.size() != 0) begin
      fail_count++;
      $display("%0t ns: %0d result words expected, got none", $time, owed_words.size());
    end
    if (fail_count == 0) begin
      $display("tb_sync_header_frame_receiver: clean");
    end else begin
      $display("tb_sync_header_frame_receiver: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_sync_header_frame_receiver: errors");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/shfr_pkg.sv
rtl/core/shfr_if.sv
rtl/core/sync_header_frame_receiver.sv
verif/tb_sync_header_frame_receiver.sv
